// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file gdda_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define GDDA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define GDDA_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== rtl/gdda_pkg.sv =====
`timescale 1ns / 1ps
package gdda_pkg;

  localparam int unsigned MapSize    = 16;
  localparam int unsigned CellBits   = 4;
  localparam int unsigned FracBits   = 12;
  localparam int unsigned TileBits   = 4;
  localparam int unsigned RecipBits  = 14 + FracBits + 1;
  localparam int unsigned StepBits   = 7;
  localparam logic [StepBits-1:0] MaxSteps = StepBits'(4 * MapSize + 4);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam logic [1:0] ST_WALL    = 2'd0;
  localparam logic [1:0] ST_LIMIT   = 2'd1;
  localparam logic [1:0] ST_LEFT    = 2'd2;
  localparam logic [1:0] ST_WRITTEN = 2'd3;

  localparam logic [31:0] DistInf    = 32'hFFFF_FFFF;
  localparam logic [17:0] DistOutMax = 18'h3FFFF;
  localparam logic [5:0]  LimitReset = 6'd24;

  typedef struct packed {
    logic               command;
    logic [3:0]         tile_x;
    logic [3:0]         tile_y;
    logic [3:0]         tile_value;
    logic [15:0]        start_x;
    logic [15:0]        start_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } item_t;

  typedef struct packed {
    logic [3:0]  hit_x;
    logic [3:0]  hit_y;
    logic [3:0]  hit_tile;
    logic        hit_side;
    logic [17:0] distance;
    logic [1:0]  status;
  } result_t;

  typedef struct packed {
    logic        is_write;
    logic [3:0]  cx;
    logic [3:0]  cy;
    logic [3:0]  tval;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] dx;
    logic [31:0] dy;
    logic        sx_neg;
    logic        sy_neg;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

endpackage

// ===== rtl/gdda_recip.sv =====
`timescale 1ns / 1ps
module gdda_recip (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [15:0]                        mag_i,
  output logic                               done_o,
  output logic [gdda_pkg::RecipBits-1:0]     quot_o
);
  // restoring division of 2^(RecipBits-1) by mag, one quotient bit per cycle
  logic [15:0] rem_q, mag_q;
  logic [gdda_pkg::RecipBits-1:0] quot_q;
  logic [4:0] cnt_q;
  logic busy_q, done_q;
  logic [16:0] trial;
  logic ge;

  assign trial = {rem_q, (cnt_q == 5'd0)};
  assign ge    = trial >= {1'b0, mag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 5'(gdda_pkg::RecipBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      mag_q  <= mag_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? 16'(trial - {1'b0, mag_q}) : trial[15:0];
      quot_q <= {quot_q[gdda_pkg::RecipBits-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

// ===== rtl/gdda_front.sv =====
`timescale 1ns / 1ps
module gdda_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  gdda_pkg::item_t       item_i,
  output logic                  busy_o,
  output gdda_pkg::qctl_t       qctl_o,
  input  logic                  full_i,
  output gdda_pkg::job_t        job_o
);
  typedef enum logic [2:0] {S_IDLE, S_WR, S_DIV, S_MUL, S_PUSH} state_e;

  state_e state_q;
  gdda_pkg::item_t item_q;
  logic div_start;
  logic done_x, done_y;
  logic [gdda_pkg::RecipBits-1:0] quot_x, quot_y;
  logic [15:0] mag_x, mag_y;
  logic pos_x, pos_y;
  logic [12:0] f_x, f_y;
  logic [31:0] delta_x, delta_y;
  logic [44:0] prod_x_q, prod_y_q;
  logic [31:0] dx_q, dy_q;
  logic [31:0] rx, ry;

  assign mag_x = item_q.dir_x[15] ? 16'(16'd0 - item_q.dir_x) : item_q.dir_x;
  assign mag_y = item_q.dir_y[15] ? 16'(16'd0 - item_q.dir_y) : item_q.dir_y;
  assign pos_x = (item_q.dir_x != '0) && !item_q.dir_x[15];
  assign pos_y = (item_q.dir_y != '0) && !item_q.dir_y[15];
  assign f_x = pos_x ? 13'(13'h1000 - {1'b0, item_q.start_x[11:0]})
                     : {1'b0, item_q.start_x[11:0]};
  assign f_y = pos_y ? 13'(13'h1000 - {1'b0, item_q.start_y[11:0]})
                     : {1'b0, item_q.start_y[11:0]};
  assign delta_x = (mag_x == '0) ? gdda_pkg::DistInf : 32'(quot_x);
  assign delta_y = (mag_y == '0) ? gdda_pkg::DistInf : 32'(quot_y);
  assign rx = prod_x_q[44] ? gdda_pkg::DistInf : prod_x_q[43:12];
  assign ry = prod_y_q[44] ? gdda_pkg::DistInf : prod_y_q[43:12];

  assign div_start = start_i && (state_q == S_IDLE) && (item_i.command == gdda_pkg::CMD_CAST);

  gdda_recip u_recip_x (
    .clk_i, .rst_ni, .start_i(div_start),
    .mag_i(item_i.dir_x[15] ? 16'(16'd0 - item_i.dir_x) : item_i.dir_x),
    .done_o(done_x), .quot_o(quot_x)
  );
  gdda_recip u_recip_y (
    .clk_i, .rst_ni, .start_i(div_start),
    .mag_i(item_i.dir_y[15] ? 16'(16'd0 - item_i.dir_y) : item_i.dir_y),
    .done_o(done_y), .quot_o(quot_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: if (start_i) begin
          state_q <= (item_i.command == gdda_pkg::CMD_CAST) ? S_DIV : S_WR;
        end
        S_WR:   if (!full_i) state_q <= S_IDLE;
        S_DIV:  if (done_x && done_y) state_q <= S_MUL;
        S_MUL:  state_q <= S_PUSH;
        S_PUSH: if (!full_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) item_q <= item_i;
    if (state_q == S_DIV && done_x && done_y) begin
      dx_q     <= delta_x;
      dy_q     <= delta_y;
      prod_x_q <= 45'(f_x) * 45'(delta_x);
      prod_y_q <= 45'(f_y) * 45'(delta_y);
    end
  end

  always_comb begin
    job_o          = '0;
    job_o.is_write = (state_q == S_WR);
    job_o.tval     = item_q.tile_value;
    job_o.cx       = (state_q == S_WR) ? item_q.tile_x : item_q.start_x[15:12];
    job_o.cy       = (state_q == S_WR) ? item_q.tile_y : item_q.start_y[15:12];
    job_o.rx       = rx;
    job_o.ry       = ry;
    job_o.dx       = dx_q;
    job_o.dy       = dy_q;
    job_o.sx_neg   = !pos_x;
    job_o.sy_neg   = !pos_y;
  end

  assign qctl_o.push = ((state_q == S_WR) || (state_q == S_PUSH)) && !full_i;
  assign qctl_o.full = full_i;
  assign busy_o = (state_q != S_IDLE);
endmodule

// ===== rtl/gdda_fifo.sv =====
`timescale 1ns / 1ps
module gdda_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gdda_pkg::qctl_t  qctl_i,
  input  gdda_pkg::job_t   job_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output gdda_pkg::job_t   job_o
);
  gdda_pkg::job_t slot_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (qctl_i.push) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(qctl_i.push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (qctl_i.push) slot_q[wr_q] <= job_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = slot_q[rd_q];
endmodule

// ===== rtl/gdda_back.sv =====
`timescale 1ns / 1ps
module gdda_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  input  logic               empty_i,
  input  gdda_pkg::job_t     job_i,
  output logic               pop_o,
  output logic               done_o,
  output gdda_pkg::result_t  result_o
);
  typedef enum logic [1:0] {S_IDLE, S_STEP, S_CHECK} state_e;

  state_e state_q;
  logic [5:0] limit_q;
  logic done_q;
  gdda_pkg::result_t res_q;
  logic [4:0] cx_q, cy_q;
  logic [31:0] rx_q, ry_q, dx_q, dy_q, dist_q;
  logic sxn_q, syn_q, side_q;
  logic [gdda_pkg::StepBits-1:0] iter_q;
  logic [gdda_pkg::TileBits-1:0] mem [gdda_pkg::MapSize*gdda_pkg::MapSize];
  logic [gdda_pkg::TileBits-1:0] rd_q;
  logic take_x, go_on;
  logic [4:0] nx, ny;
  logic [32:0] sum_x, sum_y;
  logic [3:0] cx_cl, cy_cl;
  logic [17:0] dist_out;
  logic [7:0] rd_addr;

  assign take_x = rx_q < ry_q;
  assign go_on  = (dist_q < {14'd0, limit_q, 12'd0}) && (iter_q < gdda_pkg::MaxSteps);
  assign nx     = cx_q + (sxn_q ? 5'h1F : 5'h01);
  assign ny     = cy_q + (syn_q ? 5'h1F : 5'h01);
  assign sum_x  = {1'b0, rx_q} + {1'b0, dx_q};
  assign sum_y  = {1'b0, ry_q} + {1'b0, dy_q};
  assign cx_cl  = cx_q[4] ? (sxn_q ? 4'd0 : 4'd15) : cx_q[3:0];
  assign cy_cl  = cy_q[4] ? (syn_q ? 4'd0 : 4'd15) : cy_q[3:0];
  assign dist_out = (dist_q > 32'(gdda_pkg::DistOutMax)) ? gdda_pkg::DistOutMax : dist_q[17:0];
  assign rd_addr = take_x ? {nx[3:0], cy_q[3:0]} : {cx_q[3:0], ny[3:0]};
  assign pop_o  = (state_q == S_IDLE) && !empty_i;

  always_ff @(posedge clk_i) begin
    if (pop_o && job_i.is_write) mem[{job_i.cx, job_i.cy}] <= job_i.tval;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      limit_q <= gdda_pkg::LimitReset;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      unique case (state_q)
        S_IDLE: if (!empty_i) begin
          if (job_i.is_write) begin
            done_q <= 1'b1;
            res_q  <= '{hit_x: job_i.cx, hit_y: job_i.cy, hit_tile: job_i.tval,
                        hit_side: 1'b0, distance: '0, status: gdda_pkg::ST_WRITTEN};
          end else begin
            state_q <= S_STEP;
          end
          cx_q   <= {1'b0, job_i.cx};
          cy_q   <= {1'b0, job_i.cy};
          rx_q   <= job_i.rx;
          ry_q   <= job_i.ry;
          dx_q   <= job_i.dx;
          dy_q   <= job_i.dy;
          sxn_q  <= job_i.sx_neg;
          syn_q  <= job_i.sy_neg;
          dist_q <= '0;
          side_q <= 1'b0;
          iter_q <= '0;
        end
        S_STEP: begin
          if (!go_on) begin
            done_q  <= 1'b1;
            res_q   <= '{hit_x: cx_cl, hit_y: cy_cl, hit_tile: '0, hit_side: side_q,
                         distance: dist_out, status: gdda_pkg::ST_LIMIT};
            state_q <= S_IDLE;
          end else begin
            iter_q <= iter_q + gdda_pkg::StepBits'(1);
            if (take_x) begin
              cx_q   <= nx;
              dist_q <= rx_q;
              rx_q   <= sum_x[32] ? gdda_pkg::DistInf : sum_x[31:0];
              side_q <= 1'b0;
            end else begin
              cy_q   <= ny;
              dist_q <= ry_q;
              ry_q   <= sum_y[32] ? gdda_pkg::DistInf : sum_y[31:0];
              side_q <= 1'b1;
            end
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (cx_q[4] || cy_q[4]) begin
            done_q  <= 1'b1;
            res_q   <= '{hit_x: cx_cl, hit_y: cy_cl, hit_tile: '0, hit_side: side_q,
                         distance: dist_out, status: gdda_pkg::ST_LEFT};
            state_q <= S_IDLE;
          end else if (rd_q != '0) begin
            done_q  <= 1'b1;
            res_q   <= '{hit_x: cx_cl, hit_y: cy_cl, hit_tile: rd_q, hit_side: side_q,
                         distance: dist_out, status: gdda_pkg::ST_WALL};
            state_q <= S_IDLE;
          end else begin
            state_q <= S_STEP;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;
endmodule

// ===== rtl/grid_ray_dda_traversal.sv =====
`timescale 1ns / 1ps
// grid ray caster over a 16 x 16 map of 4-bit tiles
// command channel: start_i with item_i is transferred at a clock edge where busy_o is low
// command 0 writes one tile, command 1 casts one ray from start_x/start_y along dir_x/dir_y
// result channel: done_o pulses one cycle with result_o, the receiver cannot stall it
// cfg_we_i with cfg_wdata_i sets the length limit in tiles; write it only while no command is open (unchecked)
// the front computes both reciprocal step lengths with two serial dividers,
// then a multiply and a push into a two-entry queue
// the back walks the grid cell by cell, a step state and then a check of the registered tile read
// a write result is registered when the back pops the write from the queue
// a cast result is registered when the walk hits a wall, leaves the map or reaches the
// length limit; the walk stops at 68 cells
// the front frees up after its write state, or after its divide, multiply and push states
// busy_o stays high while the front works on a command, also while a full queue holds it
// reset clears control and sets the limit to 24; the tile map is not cleared
module grid_ray_dda_traversal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  gdda_pkg::item_t    item_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic [5:0]         cfg_wdata_i,
  output logic               done_o,
  output gdda_pkg::result_t  result_o
);
  gdda_pkg::qctl_t qctl;
  gdda_pkg::job_t  job_in, job_out;
  logic full, empty, pop, front_busy;

  gdda_front u_front (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o(front_busy),
    .qctl_o(qctl), .full_i(full), .job_o(job_in)
  );

  gdda_fifo u_fifo (
    .clk_i, .rst_ni, .qctl_i(qctl), .job_i(job_in), .pop_i(pop),
    .full_o(full), .empty_o(empty), .job_o(job_out)
  );

  gdda_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .empty_i(empty), .job_i(job_out),
    .pop_o(pop), .done_o, .result_o
  );

  assign busy_o = front_busy;
endmodule

// ===== rtl/gdda_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gdda_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input gdda_pkg::result_t  result_o
);
  `GDDA_ASSERT(a_busy_after_transfer, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o, "no busy after transfer")
  `GDDA_NEVER(a_write_fields, clk_i, rst_ni, done_o && (result_o.status == gdda_pkg::ST_WRITTEN) && ((result_o.distance != '0) || result_o.hit_side), "write result with distance or side")
  `GDDA_NEVER(a_tile_on_miss, clk_i, rst_ni, done_o && ((result_o.status == gdda_pkg::ST_LIMIT) || (result_o.status == gdda_pkg::ST_LEFT)) && (result_o.hit_tile != '0), "tile on a miss")
  `GDDA_NEVER(a_wall_tile, clk_i, rst_ni, done_o && (result_o.status == gdda_pkg::ST_WALL) && (result_o.hit_tile == '0), "wall with empty tile")
endmodule

bind grid_ray_dda_traversal gdda_checker u_gdda_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .result_o(result_o)
);
